/* rtl/ddo_pkg.sv */
// ddo_pkg: shared types, constants and the sine table generator of the
// differential drive odometry block. No dependencies.
package ddo_pkg;

  // default parameter values
  localparam int DEF_SINE_TABLE_DEPTH = 1024;
  localparam int DEF_SINE_WIDTH       = 16;

  // field widths
  localparam int CNT_W      = 32;
  localparam int POS_W      = 32;
  localparam int HEADING_W  = 25;
  localparam int SCALE_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // angle arithmetic, heading in q16.16 degrees
  localparam int DEG_HALF          = 180 * 65536;
  localparam int DEG_FULL          = 360 * 65536;
  localparam int DEG_QUARTER_HALF  = 45 * 65536;
  localparam int QUADRANT_DEG      = 90;
  localparam int DEG_OFFSET        = 360 * 92;
  localparam int RECIP_90          = 11930465;
  localparam int RECIP_SHIFT       = 30;
  localparam int N1_W              = 17;
  localparam int Q1_W              = 10;
  localparam int ANG_W             = 21;
  localparam int REM_W             = 7;
  localparam int FRAC_W            = 16;

  // travel
  localparam int TRAVEL_ROUND = 256;
  localparam int TRAVEL_SHIFT = 9;
  localparam int T_W          = 49;
  localparam int T_SPLIT      = 24;

  // sequencer
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_FIRST   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_FINISH  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_RESTART = 5'd18;

  // sine series
  localparam logic [63:0] HALF_PI_Q30 = 64'h6487ED51;
  localparam longint      ONE_Q30     = 64'sd1 << 30;
  localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X       = 3'd0,
    REG_START_Y       = 3'd1,
    REG_START_HEADING = 3'd2,
    REG_MM_PER_TICK   = 3'd3,
    REG_DEG_PER_TICK  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TURN,
    MUL_TRAVEL,
    MUL_RECIP,
    MUL_DEPTH,
    MUL_X_LO,
    MUL_X_HI,
    MUL_Y_LO,
    MUL_Y_HI
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DELTA,
    OP_HEADING,
    OP_TRAVEL,
    OP_QUAD,
    OP_IDX_NUM,
    OP_INDEX,
    OP_TRIG,
    OP_ACC_LO,
    OP_ADD_X,
    OP_ADD_Y,
    OP_RESTART
  } dp_op_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_RESTART,
    BR_TO_FINISH,
    BR_FINISH
  } branch_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    dp_op_t   op;
    branch_t  br;
  } uword_t;

  typedef struct packed {
    logic     busy;
    mul_sel_t mul_sel;
    dp_op_t   op;
    logic     load_out;
  } seq_ctrl_t;

  // one table entry: sin of angle x (q30 radians) scaled by 2^(width-1)
  function automatic logic [31:0] sine_entry(logic [63:0] x, int unsigned width);
    logic [63:0] term;
    logic [63:0] mag;
    logic [63:0] rounded;
    longint      sum;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / SERIES_DIV[k-1];
      if (k[0]) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    mag     = sum;
    rounded = ((mag << (width - 1)) + (64'd1 << 29)) >> 30;
    return rounded[31:0];
  endfunction

endpackage

/* rtl/differential_drive_odometry.sv */
// differential_drive_odometry: dead-reckoning pose tracker, top level.
// Depends on ddo_pkg, ddo_sequencer and ddo_sine_rom.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    cmd, left_count, right_count
//   out      source     out_valid / out_stall  pos_x, pos_y, heading
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// a new transaction is taken only once the last one is finished; the
// microprogram runs every multiply through one shared 34x25 multiplier
// and reads the sine table through two registered ports.
// rst is synchronous, active high; it clears the pose, the last counts
// and the registers to their reset values.
// a finished result sits in the output register while the next transaction
// is taken; the sequencer holds on its last step only if that register is
// still full and stalled.
module differential_drive_odometry #(
  parameter int SINE_TABLE_DEPTH = ddo_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int SINE_WIDTH       = ddo_pkg::DEF_SINE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cmd,
  input  logic signed [ddo_pkg::CNT_W-1:0]       left_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]       right_count,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ddo_pkg::POS_W-1:0]       pos_x,
  output logic signed [ddo_pkg::POS_W-1:0]       pos_y,
  output logic signed [ddo_pkg::HEADING_W-1:0]   heading,
  // configuration
  input  logic                                   cfg_write,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import ddo_pkg::*;

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TRIG_W = SINE_WIDTH + 1;
  localparam int SHIFT  = SINE_WIDTH + 3;
  localparam int ACC_W  = SHIFT + 32;
  localparam int HSUM_W = PROD_W + 1;

  localparam logic signed [HSUM_W-1:0] H_HALF_POS = HSUM_W'(DEG_HALF);
  localparam logic signed [HSUM_W-1:0] H_HALF_NEG = -H_HALF_POS;
  localparam logic [ACC_W-1:0]         ACC_ROUND  = ACC_W'(1) << (SHIFT - 1);

  // configuration registers
  logic signed [POS_W-1:0]     start_x, start_y;
  logic signed [HEADING_W-1:0] start_heading;
  logic [SCALE_W-1:0]          mm_per_tick, deg_per_tick;

  // pose state
  logic signed [CNT_W-1:0] last_left, last_right;
  logic signed [POS_W-1:0] x_acc, y_acc;
  logic signed [31:0]      heading_acc;

  // captured transaction
  logic                    in_cmd;
  logic signed [CNT_W-1:0] in_left, in_right;

  // datapath working registers
  logic signed [CNT_W:0]        dsum, ddiff;
  logic signed [PROD_W-1:0]     prod;
  logic signed [T_W-1:0]        travel;
  logic [ANG_W-1:0]             ang_n;
  logic [1:0]                   quad;
  logic [REM_W-1:0]             rem_deg;
  logic [IDX_W-1:0]             idx, mirror;
  logic [SINE_WIDTH-1:0]        rom_idx, rom_mir;
  logic signed [TRIG_W-1:0]     sin_v, cos_v;
  logic [ACC_W-1:0]             acc;

  seq_ctrl_t ctrl;
  logic      in_accept, out_accept, out_free;

  // combinational datapath values
  logic signed [CNT_W-1:0]  dl, dr;
  logic signed [HSUM_W-1:0] h_sum;
  logic [31:0]              heading_next;
  logic signed [PROD_W-1:0] travel_sum;
  logic [N1_W-1:0]          n1;
  logic [Q1_W-1:0]          q1;
  logic [N1_W-1:0]          rem_full;
  logic [PROD_W-1:0]        idx_sum;
  logic [ACC_W-1:0]         step_sum;
  logic signed [TRIG_W-1:0] tab_idx, tab_mir;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  assign in_stall   = ctrl.busy;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;

  ddo_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .restart  (in_cmd == CMD_RESTART),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // mirrored index serves the other half of each quadrant
  assign mirror = IDX_W'(SINE_TABLE_DEPTH) - idx;

  ddo_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH),
    .WIDTH (SINE_WIDTH)
  ) u_rom (
    .clk    (clk),
    .addr_a (idx),
    .addr_b (mirror),
    .data_a (rom_idx),
    .data_b (rom_mir)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x       <= '0;
      start_y       <= '0;
      start_heading <= '0;
      mm_per_tick   <= SCALE_W'(65536);
      deg_per_tick  <= SCALE_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_X:       start_x       <= cfg_data;
        REG_START_Y:       start_y       <= cfg_data;
        REG_START_HEADING: start_heading <= cfg_data[HEADING_W-1:0];
        REG_MM_PER_TICK:   mm_per_tick   <= cfg_data[SCALE_W-1:0];
        REG_DEG_PER_TICK:  deg_per_tick  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_cmd   <= cmd;
      in_left  <= left_count;
      in_right <= right_count;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MUL_NONE: ;
      MUL_TURN: begin
        mul_a = MUL_A_W'(ddiff);
        mul_b = $signed({1'b0, deg_per_tick});
      end
      MUL_TRAVEL: begin
        mul_a = MUL_A_W'(dsum);
        mul_b = $signed({1'b0, mm_per_tick});
      end
      MUL_RECIP: begin
        mul_a = $signed({{(MUL_A_W-ANG_W){1'b0}}, ang_n});
        mul_b = MUL_B_W'(RECIP_90);
      end
      MUL_DEPTH: begin
        // remainder within the quadrant in q16.16 degrees
        mul_a = $signed({{(MUL_A_W-REM_W-FRAC_W){1'b0}}, rem_deg,
                         heading_acc[FRAC_W-1:0]});
        mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      MUL_X_LO: begin
        mul_a = $signed({{(MUL_A_W-T_SPLIT){1'b0}}, travel[T_SPLIT-1:0]});
        mul_b = MUL_B_W'(cos_v);
      end
      MUL_X_HI: begin
        // upper half of the travel keeps its sign
        mul_a = MUL_A_W'($signed(travel[T_W-1:T_SPLIT]));
        mul_b = MUL_B_W'(cos_v);
      end
      MUL_Y_LO: begin
        mul_a = $signed({{(MUL_A_W-T_SPLIT){1'b0}}, travel[T_SPLIT-1:0]});
        mul_b = MUL_B_W'(sin_v);
      end
      MUL_Y_HI: begin
        mul_a = MUL_A_W'($signed(travel[T_W-1:T_SPLIT]));
        mul_b = MUL_B_W'(sin_v);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != MUL_NONE) prod <= mul_a * mul_b;
  end

  // count deltas wrap in 32 bits
  assign dl = in_left - last_left;
  assign dr = in_right - last_right;

  // heading update with a single wrap into (-180,180]
  assign h_sum = HSUM_W'(heading_acc) + HSUM_W'(prod);
  always_comb begin
    if (h_sum > H_HALF_POS) heading_next = h_sum[31:0] - 32'(DEG_FULL);
    else if (h_sum <= H_HALF_NEG) heading_next = h_sum[31:0] + 32'(DEG_FULL);
    else heading_next = h_sum[31:0];
  end

  // travel in 1/128 mm, floor after adding half
  assign travel_sum = prod + PROD_W'(TRAVEL_ROUND);

  // whole degrees made non-negative by a multiple of a full turn
  assign n1 = N1_W'($signed(heading_acc[31:FRAC_W])) + N1_W'(DEG_OFFSET);

  // quotient by 90 through the reciprocal, exact for these ranges
  assign q1       = prod[RECIP_SHIFT +: Q1_W];
  assign rem_full = ang_n[N1_W-1:0] - N1_W'(N1_W'(q1) * N1_W'(QUADRANT_DEG));

  // table index numerator, rounded to the nearest entry
  assign idx_sum = prod + PROD_W'(DEG_QUARTER_HALF);

  assign tab_idx = $signed({1'b0, rom_idx});
  assign tab_mir = $signed({1'b0, rom_mir});

  // low partial product plus the high one shifted up, then rounded
  assign step_sum = acc + {prod[ACC_W-T_SPLIT-1:0], {T_SPLIT{1'b0}}} + ACC_ROUND;

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left   <= '0;
      last_right  <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
    end else begin
      unique case (ctrl.op)
        OP_DELTA: begin
          last_left  <= in_left;
          last_right <= in_right;
        end
        OP_HEADING: heading_acc <= heading_next;
        OP_ADD_X:   x_acc <= x_acc + step_sum[SHIFT +: POS_W];
        OP_ADD_Y:   y_acc <= y_acc + step_sum[SHIFT +: POS_W];
        OP_RESTART: begin
          x_acc       <= start_x;
          y_acc       <= start_y;
          heading_acc <= 32'(start_heading);
          last_left   <= '0;
          last_right  <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_DELTA: begin
        dsum  <= (CNT_W+1)'(dl) + (CNT_W+1)'(dr);
        ddiff <= (CNT_W+1)'(dr) - (CNT_W+1)'(dl);
      end
      OP_TRAVEL: begin
        travel <= travel_sum[TRAVEL_SHIFT +: T_W];
        ang_n  <= ANG_W'(n1);
      end
      OP_QUAD: begin
        quad    <= q1[1:0];
        rem_deg <= rem_full[REM_W-1:0];
      end
      OP_IDX_NUM: ang_n <= idx_sum[FRAC_W +: ANG_W];
      OP_INDEX:   idx   <= prod[RECIP_SHIFT +: IDX_W];
      OP_TRIG: begin
        // cosine is the sine one quadrant on
        unique case (quad)
          2'd0: begin sin_v <= tab_idx;  cos_v <= tab_mir;  end
          2'd1: begin sin_v <= tab_mir;  cos_v <= -tab_idx; end
          2'd2: begin sin_v <= -tab_idx; cos_v <= -tab_mir; end
          2'd3: begin sin_v <= -tab_mir; cos_v <= tab_idx;  end
        endcase
      end
      OP_ACC_LO: acc <= prod[ACC_W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      pos_x   <= x_acc;
      pos_y   <= y_acc;
      heading <= heading_acc[HEADING_W-1:0];
    end
  end

  // a result never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  // an accepted transaction keeps the input side stalled until it is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input not stalled after a transaction was taken");

  // a result appears only when the sequencer finishes
  a_valid_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.load_out))
    else $error("output valid without a finished transaction");

endmodule

/* rtl/ddo_sine_rom.sv */
// ddo_sine_rom: quarter-wave sine table with two registered read ports.
// Depends on ddo_pkg for the entry generator.
module ddo_sine_rom #(
  parameter int DEPTH = ddo_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int WIDTH = ddo_pkg::DEF_SINE_WIDTH
) (
  input  logic                       clk,
  input  logic [$clog2(DEPTH+1)-1:0] addr_a,
  input  logic [$clog2(DEPTH+1)-1:0] addr_b,
  output logic [WIDTH-1:0]           data_a,
  output logic [WIDTH-1:0]           data_b
);
  import ddo_pkg::*;

  logic [WIDTH-1:0] rom [DEPTH+1];

  for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
    localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(g)) / 64'(DEPTH);
    localparam logic [31:0] ENTRY = sine_entry(ANGLE, WIDTH);
    assign rom[g] = ENTRY[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    data_a <= rom[addr_a];
    data_b <= rom[addr_b];
  end

endmodule

/* rtl/ddo_sequencer.sv */
// ddo_sequencer: step counter and microprogram of the odometry datapath.
// Depends on ddo_pkg for the control word and control struct types.
module ddo_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               restart,
  input  logic               out_free,
  output ddo_pkg::seq_ctrl_t ctrl
);
  import ddo_pkg::*;

  seq_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  uword_t            uw;

  function automatic uword_t ucode(logic [STEP_W-1:0] s);
    uword_t w;
    w = '{mul_sel: MUL_NONE, op: OP_NONE, br: BR_NEXT};
    unique case (s)
      5'd0:  w = '{mul_sel: MUL_NONE,   op: OP_DELTA,   br: BR_RESTART};
      5'd1:  w = '{mul_sel: MUL_TURN,   op: OP_NONE,    br: BR_NEXT};
      5'd2:  w = '{mul_sel: MUL_TRAVEL, op: OP_HEADING, br: BR_NEXT};
      5'd3:  w = '{mul_sel: MUL_NONE,   op: OP_TRAVEL,  br: BR_NEXT};
      5'd4:  w = '{mul_sel: MUL_RECIP,  op: OP_NONE,    br: BR_NEXT};
      5'd5:  w = '{mul_sel: MUL_NONE,   op: OP_QUAD,    br: BR_NEXT};
      5'd6:  w = '{mul_sel: MUL_DEPTH,  op: OP_NONE,    br: BR_NEXT};
      5'd7:  w = '{mul_sel: MUL_NONE,   op: OP_IDX_NUM, br: BR_NEXT};
      5'd8:  w = '{mul_sel: MUL_RECIP,  op: OP_NONE,    br: BR_NEXT};
      5'd9:  w = '{mul_sel: MUL_NONE,   op: OP_INDEX,   br: BR_NEXT};
      5'd10: w = '{mul_sel: MUL_NONE,   op: OP_NONE,    br: BR_NEXT};
      5'd11: w = '{mul_sel: MUL_NONE,   op: OP_TRIG,    br: BR_NEXT};
      5'd12: w = '{mul_sel: MUL_X_LO,   op: OP_NONE,    br: BR_NEXT};
      5'd13: w = '{mul_sel: MUL_X_HI,   op: OP_ACC_LO,  br: BR_NEXT};
      5'd14: w = '{mul_sel: MUL_Y_LO,   op: OP_ADD_X,   br: BR_NEXT};
      5'd15: w = '{mul_sel: MUL_Y_HI,   op: OP_ACC_LO,  br: BR_NEXT};
      5'd16: w = '{mul_sel: MUL_NONE,   op: OP_ADD_Y,   br: BR_NEXT};
      5'd17: w = '{mul_sel: MUL_NONE,   op: OP_NONE,    br: BR_FINISH};
      5'd18: w = '{mul_sel: MUL_NONE,   op: OP_RESTART, br: BR_TO_FINISH};
      default: w = '{mul_sel: MUL_NONE, op: OP_NONE,    br: BR_FINISH};
    endcase
    return w;
  endfunction

  assign uw = ucode(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      step  <= STEP_FIRST;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_RUN;
          step_next  = STEP_FIRST;
        end
      end
      SEQ_RUN: begin
        unique case (uw.br)
          BR_NEXT:      step_next = step + 1'b1;
          BR_RESTART:   step_next = restart ? STEP_RESTART : step + 1'b1;
          BR_TO_FINISH: step_next = STEP_FINISH;
          BR_FINISH:    if (out_free) state_next = SEQ_IDLE;
        endcase
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '{busy: 1'b0, mul_sel: MUL_NONE, op: OP_NONE, load_out: 1'b0};
    unique case (state)
      SEQ_IDLE: ;
      SEQ_RUN: begin
        ctrl.busy     = 1'b1;
        ctrl.mul_sel  = uw.mul_sel;
        ctrl.op       = uw.op;
        ctrl.load_out = (uw.br == BR_FINISH) && out_free;
      end
    endcase
  end

endmodule

/* tb/odometry_checker.sv */
// odometry_checker: watches the sample, pose and register channels of the
// differential drive odometry block, predicts every pose and compares it.
// Depends on ddo_pkg for the register and command codes.
module odometry_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [ddo_pkg::CNT_W-1:0]     left_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]     right_count,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [ddo_pkg::POS_W-1:0]     pos_x,
  input  logic signed [ddo_pkg::POS_W-1:0]     pos_y,
  input  logic signed [ddo_pkg::HEADING_W-1:0] heading,
  input  logic                                 cfg_write,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                   fail_count,
  output int                                   poses_pending
);
  import ddo_pkg::*;

  localparam int     DEPTH      = DEF_SINE_TABLE_DEPTH;
  localparam int     SW         = DEF_SINE_WIDTH;
  localparam longint HALF_TURN  = 64'sd180 * 65536;
  localparam longint FULL_TURN  = 64'sd360 * 65536;
  localparam longint QUARTER    = 64'sd90 * 65536;
  localparam int     SIN_PHASE  = 0;
  localparam int     COS_PHASE  = 1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [24:0] hdg;
  } pose_t;

  pose_t       poses_due[$];
  logic [31:0] sine_lut [0:DEPTH];

  // register copies
  logic [31:0] start_x_reg, start_y_reg;
  logic [24:0] start_hdg_reg;
  logic [23:0] mm_scale, deg_scale;

  // tracked pose
  logic [31:0] prev_left, prev_right, x_acc, y_acc, hdg_acc;
  int          errs;

  // quarter-wave table, same series as the block's generator
  initial begin
    logic [63:0] ang, term, den;
    longint      acc;
    for (int i = 0; i <= DEPTH; i++) begin
      ang  = (HALF_PI_Q30 * 64'(i)) / 64'(DEPTH);
      term = ang;
      acc  = longint'(ang);
      for (int k = 1; k <= 8; k++) begin
        term = (term * ang) >> 30;
        term = (term * ang) >> 30;
        den  = 64'((2 * k) * (2 * k + 1));
        term = term / den;
        if (k % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > ONE_Q30) acc = ONE_Q30;
      sine_lut[i] = 32'(((64'(acc) << (SW - 1)) + (64'd1 << 29)) >> 30);
    end
  end

  // sine of angle plus phase quarter turns, scaled by 2^(SW-1)
  function automatic longint wave(longint angle, int phase);
    longint a, r, idx;
    int     q;
    a = angle % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    q   = int'((a / QUARTER + longint'(phase)) & 3);
    r   = a % QUARTER;
    idx = (r * DEPTH + QUARTER / 2) / QUARTER;
    case (q)
      0:       return longint'(sine_lut[idx]);
      1:       return longint'(sine_lut[DEPTH - idx]);
      2:       return -longint'(sine_lut[idx]);
      default: return -longint'(sine_lut[DEPTH - idx]);
    endcase
  endfunction

  function automatic logic [31:0] axis_step(longint travel, longint w);
    logic [63:0] p;
    p = 64'(travel) * 64'(w) + (64'd1 << (SW + 2));
    p = p >> (SW + 3);
    return p[31:0];
  endfunction

  function automatic void next_pose(logic c, logic [31:0] l, logic [31:0] r);
    logic [31:0] dif;
    longint      dl, dr, h, hs, v, t;
    if (cmd_t'(c) == CMD_RESTART) begin
      x_acc      = start_x_reg;
      y_acc      = start_y_reg;
      hdg_acc    = {{7{start_hdg_reg[24]}}, start_hdg_reg};
      prev_left  = '0;
      prev_right = '0;
    end else begin
      dif = l - prev_left;
      dl  = longint'($signed(dif));
      dif = r - prev_right;
      dr  = longint'($signed(dif));
      prev_left  = l;
      prev_right = r;
      // one wrap only, a large turn may stay outside the half circle
      h = longint'($signed(hdg_acc)) + (dr - dl) * longint'(deg_scale);
      if (h > HALF_TURN) h -= FULL_TURN;
      if (h <= -HALF_TURN) h += FULL_TURN;
      hdg_acc = h[31:0];
      hs = longint'($signed(hdg_acc));
      v  = (dl + dr) * longint'(mm_scale);
      t  = (v + TRAVEL_ROUND) >>> TRAVEL_SHIFT;
      x_acc = x_acc + axis_step(t, wave(hs, COS_PHASE));
      y_acc = y_acc + axis_step(t, wave(hs, SIN_PHASE));
    end
    poses_due.push_back('{x: x_acc, y: y_acc, hdg: hdg_acc[24:0]});
  endfunction

  always @(posedge clk) begin
    pose_t due;
    if (rst) begin
      start_x_reg   = '0;
      start_y_reg   = '0;
      start_hdg_reg = '0;
      mm_scale      = 24'd65536;
      deg_scale     = 24'd65536;
      prev_left     = '0;
      prev_right    = '0;
      x_acc         = '0;
      y_acc         = '0;
      hdg_acc       = '0;
      poses_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_X:       start_x_reg = cfg_data;
          REG_START_Y:       start_y_reg = cfg_data;
          REG_START_HEADING: start_hdg_reg = cfg_data[24:0];
          REG_MM_PER_TICK:   mm_scale = cfg_data[23:0];
          REG_DEG_PER_TICK:  deg_scale = cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (poses_due.size() == 0) begin
          $error("pose with no transaction waiting: x %0d y %0d heading %0d",
                 pos_x, pos_y, heading);
          errs++;
        end else begin
          due = poses_due.pop_front();
          if (pos_x !== due.x) begin
            $error("pos_x: expected %0d, got %0d", $signed(due.x), pos_x);
            errs++;
          end
          if (pos_y !== due.y) begin
            $error("pos_y: expected %0d, got %0d", $signed(due.y), pos_y);
            errs++;
          end
          if (heading !== due.hdg) begin
            $error("heading: expected %0d, got %0d", $signed(due.hdg), heading);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) next_pose(cmd, left_count, right_count);
    end
    fail_count    <= errs;
    poses_pending <= poses_due.size();
  end

endmodule

/* tb/tb_differential_drive_odometry.sv */
// tb_differential_drive_odometry: stimulus and verdict for the differential
// drive odometry block; depends on ddo_pkg, the block and odometry_checker.
module tb_differential_drive_odometry;
  import ddo_pkg::*;

  // clock and the one reset at the start
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic                        in_valid    = 1'b0;
  logic                        cmd         = CMD_SAMPLE;
  logic signed [CNT_W-1:0]     left_count  = '0;
  logic signed [CNT_W-1:0]     right_count = '0;
  logic                        out_stall   = 1'b0;
  logic                        cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index   = REG_START_X;
  logic [CFG_DATA_W-1:0]       cfg_data    = '0;

  // block outputs
  logic                        in_stall;
  logic                        out_valid;
  logic signed [POS_W-1:0]     pos_x;
  logic signed [POS_W-1:0]     pos_y;
  logic signed [HEADING_W-1:0] heading;

  int fail_count;
  int poses_pending;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 9;
  int unsigned stall_pct     = 51;

  // last counts sent, so most samples move a plausible distance
  logic [31:0] sent_left  = '0;
  logic [31:0] sent_right = '0;

  differential_drive_odometry dut (
    .clk, .rst,
    .in_valid, .in_stall, .cmd, .left_count, .right_count,
    .out_valid, .out_stall, .pos_x, .pos_y, .heading,
    .cfg_write, .cfg_index, .cfg_data
  );

  odometry_checker pose_check (
    .clk, .rst,
    .in_valid, .in_stall, .cmd, .left_count, .right_count,
    .out_valid, .out_stall, .pos_x, .pos_y, .heading,
    .cfg_write, .cfg_index, .cfg_data,
    .fail_count, .poses_pending
  );

  // receiver back-pressure, a fresh draw every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // offer one transaction, idling first at the sender's rate, and hold it
  // until the block takes it
  task automatic send_item(input cmd_t c, input logic [31:0] l, input logic [31:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    left_count  <= l;
    right_count <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CMD_RESTART) begin
      sent_left  = '0;
      sent_right = '0;
    end else begin
      sent_left  = l;
      sent_right = r;
    end
  endtask

  // mostly short moves from the last counts, some wild jumps and restarts
  task automatic send_random();
    int unsigned pick;
    logic [31:0] l, r;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_item(CMD_RESTART, $urandom, $urandom);
    end else if (pick < 20) begin
      send_item(CMD_SAMPLE, $urandom, $urandom);
    end else if (pick < 30) begin
      l = sent_left + 32'($urandom_range(131071)) - 32'd65536;
      r = sent_right + 32'($urandom_range(131071)) - 32'd65536;
      send_item(CMD_SAMPLE, l, r);
    end else begin
      l = sent_left + 32'($urandom_range(4000)) - 32'd2000;
      r = sent_right + 32'($urandom_range(4000)) - 32'd2000;
      send_item(CMD_SAMPLE, l, r);
    end
  endtask

  // stop offering and wait until every pose has come back, so the block
  // is idle before registers change
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (poses_pending != 0) @(posedge clk);
  endtask

  // write all five registers back to back, one per cycle
  task automatic load_settings(input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] sh, input logic [23:0] mm,
                               input logic [23:0] deg);
    cfg_write <= 1'b1;
    cfg_index <= REG_START_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= REG_START_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_index <= REG_START_HEADING;
    cfg_data  <= sh;
    @(posedge clk);
    cfg_index <= REG_MM_PER_TICK;
    cfg_data  <= {8'd0, mm};
    @(posedge clk);
    cfg_index <= REG_DEG_PER_TICK;
    cfg_data  <= {8'd0, deg};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [24:0] raw_hdg;
    int          hdg_val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset scales first: 1 mm and 1 degree per tick
    send_item(CMD_SAMPLE, 32'd0, 32'd0);                 // no motion
    send_item(CMD_SAMPLE, 32'd100, 32'd100);             // straight ahead
    send_item(CMD_SAMPLE, 32'd100, 32'd280);             // turn to exactly +180
    send_item(CMD_SAMPLE, 32'd100, 32'd281);             // past +180, wraps to -179
    send_item(CMD_SAMPLE, -32'sd900, 32'd281);           // turn too big for one wrap
    send_item(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000); // count extremes
    send_item(CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF); // deltas wrap around
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_RESTART, 32'hFFFF_FFFF, 32'h8000_0000); // counts ignored
    send_item(CMD_SAMPLE, 32'd0, -32'sd180);             // lands on -180, goes to +180
    send_item(CMD_SAMPLE, 32'd500, 32'd320);

    // start pose at the corners, full travel scale, zero turn scale
    drain();
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'sd11796480, 24'hFF_FFFF, 24'd0);
    send_item(CMD_RESTART, 32'd0, 32'd0);
    send_item(CMD_SAMPLE, 32'd1000, 32'd3000);
    send_item(CMD_SAMPLE, -32'sd5000, 32'd7);

    // start heading below the half circle, zero travel, full turn scale
    drain();
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, -32'sd16777216, 24'd0, 24'hFF_FFFF);
    send_item(CMD_RESTART, 32'd0, 32'd0);
    send_item(CMD_SAMPLE, 32'd10, 32'd11);               // turn brings that heading back inside
    send_item(CMD_SAMPLE, 32'd10, 32'd11);               // zero deltas
    send_item(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_RESTART, 32'd5, 32'd5);
    send_item(CMD_SAMPLE, 32'd2, 32'd1);

    // lowest legal start heading, unit scales
    drain();
    load_settings(32'd0, 32'd0, -32'sd11796479, 24'd65536, 24'd65536);
    send_item(CMD_RESTART, 32'd0, 32'd0);
    send_item(CMD_SAMPLE, 32'd45, 32'd45);
    send_item(CMD_SAMPLE, 32'd45, 32'd135);              // quarter-turn boundary

    // random part: six segments, a new setting before each,
    // two per idling phase
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 51;
        stall_pct     = 9;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      drain();
      case (seg)
        1: load_settings(32'h8000_0000, 32'h7FFF_FFFF, -32'sd11796479,
                         24'hFF_FFFF, 24'hFF_FFFF);
        3: load_settings(32'd0, 32'd0, 32'sd11796480, 24'd0, 24'd0);
        default: begin
          if ($urandom_range(4) == 0) begin
            raw_hdg = 25'($urandom);
          end else begin
            hdg_val = int'($urandom_range(23592959)) - 11796479;
            raw_hdg = hdg_val[24:0];
          end
          load_settings($urandom, $urandom, {{7{raw_hdg[24]}}, raw_hdg},
                        ($urandom_range(1) == 0) ? 24'($urandom_range(262143))
                                                 : 24'($urandom),
                        ($urandom_range(1) == 0) ? 24'($urandom_range(131072))
                                                 : 24'($urandom));
        end
      endcase
      // open each segment from the start pose
      send_item(CMD_RESTART, $urandom, $urandom);
      repeat (156) send_random();
    end

    // all sent: wait for the last poses, then a little longer than one
    // sample's latency in case anything stray comes out
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && poses_pending == 0) begin
      $display("tb_differential_drive_odometry: done, clean");
    end else begin
      $display("tb_differential_drive_odometry: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("tb_differential_drive_odometry: done, errors");
    $finish;
  end

endmodule
